### rtl/core/ryw_pkg.sv
// Shared types and constants of the RGB to YUV 4:2:0 frame writer.
package ryw_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam int ADDR_W = 23;
    localparam int LUMA_W = 22;
    localparam int CFG_W  = 12;
    localparam int FMT_W  = 2;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_IDX_FORMAT = 2'd2;

    localparam logic [CFG_W-1:0] RST_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 12'd480;

    localparam logic [FMT_W-1:0] FMT_NV12 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_NV21 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_I420 = 2'd2;

    // BT.601 integer coefficients
    localparam int Y_R = 66;
    localparam int Y_G = 129;
    localparam int Y_B = 25;
    localparam int U_R = -38;
    localparam int U_G = -74;
    localparam int U_B = 112;
    localparam int V_R = 112;
    localparam int V_G = -94;
    localparam int V_B = -18;
    localparam int ROUND_OFS   = 128;
    localparam int CHROMA_BIAS = 32768;
    localparam logic [7:0] Y_OFS = 8'd16;

    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);

    // One converted pixel waiting for the byte sequencer
    typedef struct packed {
        logic [7:0]        y;
        logic [7:0]        u;
        logic [7:0]        v;
        logic              chroma;
        logic              frame_start;
        logic              last_frame;
        logic [FMT_W-1:0]  fmt;
        logic [ADDR_W-1:0] area;
        logic [ADDR_W-1:0] area2;
    } t_job;

endpackage

### rtl/core/ryw_front.sv
// Front end: raster position tracking, color conversion and frame area pipeline.
module ryw_front import ryw_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [31:0]      i_pixel_argb,
    input  logic [CFG_W-1:0] i_cfg_width,
    input  logic [CFG_W-1:0] i_cfg_height,
    input  logic [FMT_W-1:0] i_cfg_format,
    output logic             o_job_push,
    output t_job             o_job,
    input  logic             i_job_full
);

    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int CWW    = (WW > CFG_W) ? WW : CFG_W;
    localparam int CHW    = (HW > CFG_W) ? HW : CFG_W;
    localparam int COL_W  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PROD_W = WW + HW;

    logic [CWW-1:0]   w_ext;
    logic [CHW-1:0]   h_ext;
    logic [WW-1:0]    w_sat;
    logic [HW-1:0]    h_sat;
    logic             adv;
    logic             accept;
    logic             row_end;
    logic             frame_end;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic             r_s1_valid;
    logic [7:0]       r_s1_r, r_s1_g, r_s1_b;
    logic             r_s1_chroma, r_s1_fs, r_s1_lf;
    logic [FMT_W-1:0] r_s1_fmt;
    logic [WW-1:0]    r_s1_w;
    logic [HW-1:0]    r_s1_h;

    logic              r_s2_valid;
    logic [15:0]       r_s2_ys, r_s2_us, r_s2_vs;
    logic              r_s2_chroma, r_s2_fs, r_s2_lf;
    logic [FMT_W-1:0]  r_s2_fmt;
    logic [PROD_W-1:0] r_s2_prod;
    logic [ADDR_W-1:0] area;

    always_comb begin
        w_ext = CWW'(i_cfg_width);
        h_ext = CHW'(i_cfg_height);
        if (w_ext < CWW'(2)) begin
            w_sat = WW'(2);
        end else if (w_ext > CWW'(MAX_WIDTH)) begin
            w_sat = WW'(MAX_WIDTH);
        end else begin
            w_sat = WW'(w_ext);
        end
        if (h_ext < CHW'(2)) begin
            h_sat = HW'(2);
        end else if (h_ext > CHW'(MAX_HEIGHT)) begin
            h_sat = HW'(MAX_HEIGHT);
        end else begin
            h_sat = HW'(h_ext);
        end
    end

    // whole pipeline moves only while the job queue has room
    assign adv       = !i_job_full;
    assign o_full    = !adv;
    assign accept    = i_push && adv;
    assign row_end   = (WW'(r_col) + WW'(1)) >= w_sat;
    assign frame_end = row_end && ((HW'(r_row) + HW'(1)) >= h_sat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (frame_end) begin
                r_col <= '0;
                r_row <= '0;
            end else if (row_end) begin
                r_col <= '0;
                r_row <= r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_r      <= i_pixel_argb[23:16];
            r_s1_g      <= i_pixel_argb[15:8];
            r_s1_b      <= i_pixel_argb[7:0];
            r_s1_chroma <= !r_row[0] && !r_col[0];
            r_s1_fs     <= (r_row == '0) && (r_col == '0);
            r_s1_lf     <= frame_end;
            r_s1_fmt    <= i_cfg_format;
            r_s1_w      <= w_sat;
            r_s1_h      <= h_sat;
        end
    end

    // sums stay in 0..65535 with the bias, so the byte is bits 15..8 without clamping
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_ys <= 16'(Y_R * int'(r_s1_r) + Y_G * int'(r_s1_g) + Y_B * int'(r_s1_b)
                           + ROUND_OFS);
            r_s2_us <= 16'(U_R * int'(r_s1_r) + U_G * int'(r_s1_g) + U_B * int'(r_s1_b)
                           + ROUND_OFS + CHROMA_BIAS);
            r_s2_vs <= 16'(V_R * int'(r_s1_r) + V_G * int'(r_s1_g) + V_B * int'(r_s1_b)
                           + ROUND_OFS + CHROMA_BIAS);
            r_s2_prod   <= PROD_W'(r_s1_w) * PROD_W'(r_s1_h);
            r_s2_chroma <= r_s1_chroma;
            r_s2_fs     <= r_s1_fs;
            r_s2_lf     <= r_s1_lf;
            r_s2_fmt    <= r_s1_fmt;
        end
    end

    assign area = ADDR_W'(r_s2_prod);

    always_comb begin
        o_job.y           = r_s2_ys[15:8] + Y_OFS;
        o_job.u           = r_s2_us[15:8];
        o_job.v           = r_s2_vs[15:8];
        o_job.chroma      = r_s2_chroma;
        o_job.frame_start = r_s2_fs;
        o_job.last_frame  = r_s2_lf;
        o_job.fmt         = r_s2_fmt;
        o_job.area        = area;
        o_job.area2       = area + (area >> 2);
    end

    assign o_job_push = r_s2_valid && adv;

endmodule

### rtl/core/ryw_job_fifo.sv
// Short job queue between the front end and the byte sequencer.
module ryw_job_fifo import ryw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_data,
    output logic o_full,
    input  logic i_rd,
    output logic o_empty,
    output t_job o_data
);

    t_job                 r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] r_wr_ptr;
    logic [JOB_PTR_W-1:0] r_rd_ptr;
    logic [JOB_PTR_W:0]   r_count;
    logic                 do_wr;
    logic                 do_rd;

    assign o_full  = r_count == (JOB_PTR_W + 1)'(JOB_DEPTH);
    assign o_empty = r_count == '0;
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + JOB_PTR_W'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + JOB_PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + (JOB_PTR_W + 1)'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - (JOB_PTR_W + 1)'(1);
            end
        end
    end

endmodule

### rtl/core/ryw_back.sv
// Back end: plane address tracking and per-byte sequencing into the result register.
module ryw_back import ryw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_empty,
    input  t_job              i_job,
    output logic              o_job_pop,
    input  logic              pop,
    output logic              empty,
    output logic [ADDR_W-1:0] o_byte_address,
    output logic [7:0]        o_byte_value,
    output logic              o_last_of_pixel,
    output logic              o_last_of_frame
);

    localparam logic [1:0] STEP_Y  = 2'd0;
    localparam logic [1:0] STEP_C0 = 2'd1;
    localparam logic [1:0] STEP_C1 = 2'd2;

    logic [1:0]        r_step;
    logic [LUMA_W-1:0] r_luma;
    logic [ADDR_W-1:0] r_c;
    logic [ADDR_W-1:0] r_c2;

    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    logic [7:0]        r_out_val;
    logic              r_out_lp;
    logic              r_out_lf;

    logic              load;
    logic              last_step;
    logic              is_nv12;
    logic              is_nv21;
    logic              is_i420;
    logic [LUMA_W-1:0] eff_luma;
    logic [ADDR_W-1:0] eff_c;
    logic [ADDR_W-1:0] eff_c2;
    logic [ADDR_W-1:0] sel_addr;
    logic [7:0]        sel_val;

    assign load      = !i_job_empty && (!r_out_valid || pop);
    assign last_step = ((r_step == STEP_Y) && !i_job.chroma) || (r_step == STEP_C1);
    assign o_job_pop = load && last_step;

    assign is_nv12 = i_job.fmt == FMT_NV12;
    assign is_nv21 = i_job.fmt == FMT_NV21;
    assign is_i420 = !is_nv12 && !is_nv21;

    // plane bases are reloaded on the first byte of a frame
    assign eff_luma = i_job.frame_start ? '0 : r_luma;
    assign eff_c    = i_job.frame_start ? i_job.area : r_c;
    assign eff_c2   = i_job.frame_start ? i_job.area2 : r_c2;

    always_comb begin
        unique case (r_step)
            STEP_Y: begin
                sel_addr = ADDR_W'(eff_luma);
                sel_val  = i_job.y;
            end
            STEP_C0: begin
                sel_addr = r_c;
                sel_val  = is_nv21 ? i_job.v : i_job.u;
            end
            STEP_C1: begin
                sel_addr = is_i420 ? r_c2 : r_c + ADDR_W'(1);
                sel_val  = is_nv21 ? i_job.u : i_job.v;
            end
            default: begin
                sel_addr = '0;
                sel_val  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_Y;
            r_luma <= '0;
            r_c    <= '0;
            r_c2   <= '0;
        end else if (load) begin
            unique case (r_step)
                STEP_Y: begin
                    r_luma <= eff_luma + LUMA_W'(1);
                    r_c    <= eff_c;
                    r_c2   <= eff_c2;
                    r_step <= i_job.chroma ? STEP_C0 : STEP_Y;
                end
                STEP_C0: begin
                    r_step <= STEP_C1;
                end
                STEP_C1: begin
                    r_step <= STEP_Y;
                    r_c    <= r_c + (is_i420 ? ADDR_W'(1) : ADDR_W'(2));
                    if (is_i420) begin
                        r_c2 <= r_c2 + ADDR_W'(1);
                    end
                end
                default: begin
                    r_step <= STEP_Y;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_addr <= sel_addr;
            r_out_val  <= sel_val;
            r_out_lp   <= last_step;
            r_out_lf   <= last_step && i_job.last_frame;
        end
    end

    assign empty           = !r_out_valid;
    assign o_byte_address  = r_out_addr;
    assign o_byte_value    = r_out_val;
    assign o_last_of_pixel = r_out_lp;
    assign o_last_of_frame = r_out_lf;

endmodule

### rtl/core/rgb_to_yuv420_frame_writer_core.sv
// Top level of the BT.601 RGB to YUV 4:2:0 frame writer with configuration registers.
//
// Pixels enter in raster order, one per cycle when the job queue has room, and pass a
// two-stage conversion pipeline into a four-entry job queue; a byte sequencer then
// drives one result byte per cycle while the consumer pops (Y, then the two chroma
// bytes on even rows and columns), so a pixel yields one byte on other positions and
// three bytes on chroma positions, 1.5 bytes per pixel averaged over a frame. The byte
// sequencer's one-byte-per-cycle output register sets the sustained rate; the first
// byte of a pixel passes the two conversion stages, the job queue and the output
// register before it reaches the result ports. Width and height are saturated to
// 2..MAX_WIDTH and 2..MAX_HEIGHT, and format code 3 behaves as I420.
module rgb_to_yuv420_frame_writer_core import ryw_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [31:0]       i_pixel_argb,
    output logic              empty,
    input  logic              pop,
    output logic [ADDR_W-1:0] o_byte_address,
    output logic [7:0]        o_byte_value,
    output logic              o_last_of_pixel,
    output logic              o_last_of_frame,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic [FMT_W-1:0] r_format;

    logic job_push;
    logic job_full;
    logic job_empty;
    logic job_pop;
    t_job job_in;
    t_job job_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_format <= FMT_NV12;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_IDX_WIDTH:  r_width  <= i_cfg_data;
                CFG_IDX_HEIGHT: r_height <= i_cfg_data;
                CFG_IDX_FORMAT: r_format <= i_cfg_data[FMT_W-1:0];
                default: ;
            endcase
        end
    end

    ryw_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_pixel_argb(i_pixel_argb),
        .i_cfg_width (r_width),
        .i_cfg_height(r_height),
        .i_cfg_format(r_format),
        .o_job_push  (job_push),
        .o_job       (job_in),
        .i_job_full  (job_full)
    );

    ryw_job_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (job_push),
        .i_data (job_in),
        .o_full (job_full),
        .i_rd   (job_pop),
        .o_empty(job_empty),
        .o_data (job_out)
    );

    ryw_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_empty    (job_empty),
        .i_job          (job_out),
        .o_job_pop      (job_pop),
        .pop            (pop),
        .empty          (empty),
        .o_byte_address (o_byte_address),
        .o_byte_value   (o_byte_value),
        .o_last_of_pixel(o_last_of_pixel),
        .o_last_of_frame(o_last_of_frame)
    );

    // end of frame is always the closing byte of its pixel
    a_lf_is_lp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last_of_frame) |-> o_last_of_pixel)
        else $error("last_of_frame without last_of_pixel");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue state not cleared by reset");

    // a queued job must never be dropped: a push while the queue is full stalls the input
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_push |-> !job_full)
        else $error("job pushed into a full queue");

endmodule
